@@ design/skc_pkg.sv @@
// ----------------------------------------------------------------------------
// skc_pkg
// Types, register indexes, step codes and constants of the stereo compressor.
// ----------------------------------------------------------------------------
package skc_pkg;

    typedef struct packed {
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
    } t_frame_in;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } t_frame_out;

    typedef struct packed {
        logic signed [14:0] threshold_db;
        logic [16:0]        inverse_ratio;
        logic [12:0]        knee_width_db;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic [16:0]        makeup_gain;
    } t_cfg;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_INV_RATIO = 3'd1;
    localparam logic [2:0] CFG_KNEE      = 3'd2;
    localparam logic [2:0] CFG_ATTACK    = 3'd3;
    localparam logic [2:0] CFG_RELEASE   = 3'd4;
    localparam logic [2:0] CFG_MAKEUP    = 3'd5;
    localparam logic [2:0] CFG_ENABLE    = 3'd6;

    localparam logic [4:0] STEP_IDLE  = 5'd0;
    localparam logic [4:0] STEP_NORM  = 5'd1;
    localparam logic [4:0] STEP_LOG1  = 5'd2;
    localparam logic [4:0] STEP_LOG2  = 5'd3;
    localparam logic [4:0] STEP_LOG3  = 5'd4;
    localparam logic [4:0] STEP_LOG4  = 5'd5;
    localparam logic [4:0] STEP_ENV1  = 5'd6;
    localparam logic [4:0] STEP_ENV2  = 5'd7;
    localparam logic [4:0] STEP_ENV3  = 5'd8;
    localparam logic [4:0] STEP_GAIN1 = 5'd9;
    localparam logic [4:0] STEP_GAIN2 = 5'd10;
    localparam logic [4:0] STEP_GAIN3 = 5'd11;
    localparam logic [4:0] STEP_KNEE1 = 5'd12;
    localparam logic [4:0] STEP_KNEE2 = 5'd13;
    localparam logic [4:0] STEP_DIV   = 5'd14;
    localparam logic [4:0] STEP_KNEE3 = 5'd15;
    localparam logic [4:0] STEP_EXP1  = 5'd16;
    localparam logic [4:0] STEP_EXP2  = 5'd17;
    localparam logic [4:0] STEP_EXP3  = 5'd18;
    localparam logic [4:0] STEP_EXP4  = 5'd19;
    localparam logic [4:0] STEP_EXP5  = 5'd20;
    localparam logic [4:0] STEP_EXP6  = 5'd21;
    localparam logic [4:0] STEP_EXP7  = 5'd22;
    localparam logic [4:0] STEP_SCL1  = 5'd23;
    localparam logic [4:0] STEP_SCL2  = 5'd24;
    localparam logic [4:0] STEP_SCL3  = 5'd25;
    localparam logic [4:0] STEP_SCL4  = 5'd26;
    localparam logic [4:0] STEP_DONE  = 5'd27;

    localparam int DIV_BITS = 13;

    localparam logic signed [16:0] LVL_FLOOR = -17'sd24576;
    localparam logic [18:0] DB_PER_OCT = 19'd394566;
    localparam logic [14:0] POLY_K     = 15'd22589;
    localparam logic [15:0] POLY_L     = 16'd42947;
    localparam logic signed [41:0] OCT_PER_DB = 42'sd2786635;

    localparam logic signed [14:0] RST_THRESHOLD = -15'sd5120;
    localparam logic [16:0] RST_INV_RATIO = 17'd65536;
    localparam logic [12:0] RST_KNEE      = 13'd0;
    localparam logic [15:0] RST_ATTACK    = 16'd65400;
    localparam logic [15:0] RST_RELEASE   = 16'd65522;
    localparam logic [16:0] RST_MAKEUP    = 17'd4096;

    typedef struct packed {
        logic [4:0] step;
        logic       load;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic norm_done;
        logic knee;
    } t_dp_stat;

endpackage

@@ design/skc_ctrl.sv @@
// ----------------------------------------------------------------------------
// skc_ctrl
// Sequencer of the compressor: steps the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module skc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_enable,
    input  skc_pkg::t_dp_stat i_stat,
    output skc_pkg::t_dp_cmd  o_cmd
);
    import skc_pkg::*;

    logic [4:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;
    logic       w_accept;
    logic       w_slot;

    assign o_in_ready  = (r_state == STEP_IDLE);
    assign o_out_valid = r_ovalid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot      = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            STEP_IDLE: begin
                if (w_accept) begin
                    n_state = i_enable ? STEP_NORM : STEP_DONE;
                end
            end
            STEP_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = STEP_LOG1;
                end
            end
            STEP_LOG1:  n_state = STEP_LOG2;
            STEP_LOG2:  n_state = STEP_LOG3;
            STEP_LOG3:  n_state = STEP_LOG4;
            STEP_LOG4:  n_state = STEP_ENV1;
            STEP_ENV1:  n_state = STEP_ENV2;
            STEP_ENV2:  n_state = STEP_ENV3;
            STEP_ENV3:  n_state = STEP_GAIN1;
            STEP_GAIN1: n_state = STEP_GAIN2;
            STEP_GAIN2: n_state = STEP_GAIN3;
            STEP_GAIN3: n_state = i_stat.knee ? STEP_KNEE1 : STEP_EXP1;
            STEP_KNEE1: n_state = STEP_KNEE2;
            STEP_KNEE2: begin
                n_state = STEP_DIV;
                n_cnt   = '0;
            end
            STEP_DIV: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_BITS - 1)) begin
                    n_state = STEP_KNEE3;
                end
            end
            STEP_KNEE3: n_state = STEP_EXP1;
            STEP_EXP1:  n_state = STEP_EXP2;
            STEP_EXP2:  n_state = STEP_EXP3;
            STEP_EXP3:  n_state = STEP_EXP4;
            STEP_EXP4:  n_state = STEP_EXP5;
            STEP_EXP5:  n_state = STEP_EXP6;
            STEP_EXP6:  n_state = STEP_EXP7;
            STEP_EXP7:  n_state = STEP_SCL1;
            STEP_SCL1:  n_state = STEP_SCL2;
            STEP_SCL2:  n_state = STEP_SCL3;
            STEP_SCL3:  n_state = STEP_SCL4;
            STEP_SCL4:  n_state = STEP_DONE;
            STEP_DONE: begin
                if (w_slot) begin
                    n_state = STEP_IDLE;
                end
            end
            default:    n_state = STEP_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_state == STEP_DONE && w_slot) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= STEP_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_cmd.step     = r_state;
    assign o_cmd.load     = w_accept;
    assign o_cmd.out_load = (r_state == STEP_DONE) && w_slot;

endmodule

@@ design/skc_dp.sv @@
// ----------------------------------------------------------------------------
// skc_dp
// Datapath: level detector, envelope, gain computer, exp2 and sample scaling.
// ----------------------------------------------------------------------------
module skc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skc_pkg::t_dp_cmd    i_cmd,
    output skc_pkg::t_dp_stat   o_stat,
    input  skc_pkg::t_frame_in  i_word,
    input  skc_pkg::t_cfg       i_cfg,
    input  logic                i_env_load,
    output skc_pkg::t_frame_out o_word
);
    import skc_pkg::*;

    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        abs24 = v[23] ? 24'(-v) : 24'(v);
    endfunction

    function automatic logic [23:0] scale_smp(input logic [53:0] mag, input logic neg,
                                              input logic signed [10:0] xi);
        logic signed [11:0] s;
        logic [11:0]        sh;
        logic [11:0]        k;
        logic [54:0]        rs;
        logic [54:0]        mo;
        logic [24:0]        lim;
        logic               sat;
        logic               big;
        s   = 12'sd23 - 12'(xi);
        sh  = '0;
        k   = '0;
        rs  = '0;
        mo  = '0;
        lim = '0;
        sat = 1'b0;
        if (s > 12'sd0) begin
            sh = 12'(s - 12'sd1);
            rs = {1'b0, mag} >> sh;
            mo = (rs + 55'd1) >> 1;
        end else begin
            k = 12'(-s);
            if (mag != '0) begin
                if (k > 12'd24) begin
                    sat = 1'b1;
                end else begin
                    lim = 25'd1 << (12'd24 - k);
                    if (mag > 54'(lim)) begin
                        sat = 1'b1;
                    end else begin
                        mo = 55'(mag) << k;
                    end
                end
            end
        end
        if (neg) begin
            big = sat || (mo > 55'h800000);
            scale_smp = big ? 24'h800000 : 24'(55'd0 - mo);
        end else begin
            big = sat || (mo > 55'h7FFFFF);
            scale_smp = big ? 24'h7FFFFF : mo[23:0];
        end
    endfunction

    logic signed [23:0] r_l, r_r;
    logic [23:0]        r_m;
    logic [4:0]         r_e;
    logic [46:0]        r_t;
    logic [61:0]        r_u;
    logic [27:0]        r_neg;
    logic signed [16:0] r_lvl;
    logic signed [16:0] r_env;
    logic signed [17:0] r_diff;
    logic [15:0]        r_coef;
    logic signed [34:0] r_prod;
    logic signed [17:0] r_d;
    logic [13:0]        r_y2;
    logic               r_below, r_above;
    logic signed [34:0] r_hp;
    logic [30:0]        r_m1;
    logic [44:0]        r_num;
    logic [12:0]        r_rem;
    logic [12:0]        r_dq;
    logic signed [18:0] r_g;
    logic signed [41:0] r_xp;
    logic signed [10:0] r_xi;
    logic [22:0]        r_xf;
    logic [38:0]        r_inner;
    logic [38:0]        r_pl;
    logic [45:0]        r_ph;
    logic [24:0]        r_poly;
    logic [29:0]        r_gm;
    logic [53:0]        r_mag;
    logic [23:0]        r_lo, r_ro;
    t_frame_out         r_out;

    logic [23:0]        w_ail, w_air;
    logic signed [17:0] w_s;
    logic [16:0]        w_abs_s;
    logic [22:0]        w_frac;
    logic [46:0]        w_lp;
    logic signed [16:0] w_lvl;
    logic signed [34:0] w_adj;
    logic signed [19:0] w_envn;
    logic signed [16:0] w_envs;
    logic signed [18:0] w_d2;
    logic signed [18:0] w_w;
    logic signed [34:0] w_hadj;
    logic [45:0]        w_a;
    logic [13:0]        w_rem2;
    logic               w_qbit;
    logic signed [41:0] w_x;
    logic [61:0]        w_ps;
    logic [41:0]        w_gp;

    always_comb begin
        w_ail   = abs24(i_word.left_in);
        w_air   = abs24(i_word.right_in);
        w_s     = $signed({1'b0, i_cfg.inverse_ratio}) - 18'sd65536;
        w_abs_s = w_s[17] ? 17'(-w_s) : 17'(w_s);
        w_frac  = r_m[22:0] - r_u[61:39];
        w_lp    = 47'(r_neg) * 47'(DB_PER_OCT) + (47'd1 << 30);
        w_lvl   = (r_m == '0) ? LVL_FLOOR : 17'sd0 - $signed({1'b0, w_lp[46:31]});
        w_adj   = (r_prod + 35'sd32768) >>> 16;
        w_envn  = 20'(r_lvl) + 20'(w_adj);
        if (w_envn > 20'sd65535) begin
            w_envs = 17'sd65535;
        end else if (w_envn < -20'sd65536) begin
            w_envs = -17'sd65536;
        end else begin
            w_envs = 17'(w_envn);
        end
        w_d2    = $signed({r_d, 1'b0});
        w_w     = $signed({6'b0, i_cfg.knee_width_db});
        w_hadj  = (r_hp + 35'sd32768) >>> 16;
        w_a     = 46'(r_num) + (46'(i_cfg.knee_width_db) << 18);
        w_rem2  = {r_rem, r_dq[12]};
        w_qbit  = (w_rem2 >= {1'b0, i_cfg.knee_width_db});
        w_x     = (r_xp + 42'sd256) >>> 9;
        w_ps    = (62'(r_ph) << 16) + 62'(r_pl);
        w_gp    = 42'(r_poly) * 42'(i_cfg.makeup_gain);
    end

    assign o_stat.norm_done = r_m[23] || (r_m == '0);
    assign o_stat.knee      = !r_below && !r_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= LVL_FLOOR;
        end else if (i_env_load) begin
            r_env <= 17'(i_cfg.threshold_db);
        end else if (i_cmd.step == STEP_ENV3) begin
            r_env <= w_envs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l  <= i_word.left_in;
            r_r  <= i_word.right_in;
            r_lo <= i_word.left_in;
            r_ro <= i_word.right_in;
            r_m  <= (w_ail > w_air) ? w_ail : w_air;
            r_e  <= 5'd23;
        end
        if (i_cmd.out_load) begin
            r_out.left_out  <= r_lo;
            r_out.right_out <= r_ro;
        end
        case (i_cmd.step)
            STEP_NORM: begin
                if (!r_m[23] && r_m != '0) begin
                    r_m <= r_m << 1;
                    r_e <= r_e - 5'd1;
                end
            end
            STEP_LOG1:  r_t   <= {24'b0, r_m[22:0]} * {23'b0, 1'b1, r_m[22:0]};
            STEP_LOG2:  r_u   <= 62'(r_t) * 62'(POLY_K);
            STEP_LOG3:  r_neg <= {5'd23 - r_e, 23'b0} - 28'(w_frac);
            STEP_LOG4:  r_lvl <= w_lvl;
            STEP_ENV1: begin
                r_diff <= 18'(r_env) - 18'(r_lvl);
                r_coef <= (r_lvl > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;
            end
            STEP_ENV2:  r_prod <= 35'($signed({1'b0, r_coef})) * 35'(r_diff);
            STEP_GAIN1: r_d <= 18'(r_env) - 18'(i_cfg.threshold_db);
            STEP_GAIN2: begin
                r_below <= (w_d2 <= -w_w);
                r_above <= (w_d2 >= w_w);
                r_y2    <= 14'(w_d2 + w_w);
                r_hp    <= 35'(r_d) * 35'(w_s);
            end
            STEP_GAIN3: begin
                r_g  <= r_below ? 19'sd0 : 19'(w_hadj);
                r_m1 <= 31'(w_abs_s) * 31'(r_y2);
            end
            STEP_KNEE1: r_num <= 45'(r_m1) * 45'(r_y2);
            STEP_KNEE2: begin
                r_rem <= w_a[44:32];
                r_dq  <= w_a[31:19];
            end
            STEP_DIV: begin
                r_rem <= w_qbit ? 13'(w_rem2 - {1'b0, i_cfg.knee_width_db}) : w_rem2[12:0];
                r_dq  <= {r_dq[11:0], w_qbit};
            end
            STEP_KNEE3: begin
                r_g <= w_s[17] ? 19'sd0 - $signed({6'b0, r_dq}) : $signed({6'b0, r_dq});
            end
            STEP_EXP1:  r_xp <= 42'(r_g) * OCT_PER_DB;
            STEP_EXP2: begin
                r_xi <= w_x[33:23];
                r_xf <= w_x[22:0];
            end
            STEP_EXP3:  r_inner <= (39'(POLY_L) << 23) + 39'(r_xf) * 39'(POLY_K);
            STEP_EXP4:  r_pl <= 39'(r_xf) * 39'(r_inner[15:0]);
            STEP_EXP5:  r_ph <= 46'(r_xf) * 46'(r_inner[38:16]);
            STEP_EXP6:  r_poly <= (25'd1 << 23) + 25'(w_ps[61:39]);
            STEP_EXP7:  r_gm <= w_gp[41:12];
            STEP_SCL1:  r_mag <= 54'(abs24(r_l)) * 54'(r_gm);
            STEP_SCL2:  r_lo <= scale_smp(r_mag, r_l[23], r_xi);
            STEP_SCL3:  r_mag <= 54'(abs24(r_r)) * 54'(r_gm);
            STEP_SCL4:  r_ro <= scale_smp(r_mag, r_r[23], r_xi);
            default: begin
            end
        endcase
    end

    assign o_word = r_out;

endmodule

@@ design/stereo_soft_knee_compressor.sv @@
// ----------------------------------------------------------------------------
// stereo_soft_knee_compressor
// Feed-forward stereo compressor with soft knee, dB-domain envelope and makeup.
// ----------------------------------------------------------------------------
// One frame at a time. Disabled, a taken frame goes straight from idle to the
// done step, where the result word is loaded. Enabled, the frame first passes
// the normalize step, which shifts out the leading zeros of the peak magnitude
// (up to 23), and passes the knee steps only when the envelope is inside the
// soft knee, where a 13-step restoring divider runs; a single sequencer steps
// one multiply at a time through log2, envelope, gain and exp2. The next frame
// is taken in the cycle after the result is loaded, and a result still waiting
// at the output holds the sequencer. Config writes are always taken and must
// only be made while no frame is in flight.
module stereo_soft_knee_compressor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  skc_pkg::t_frame_in  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output skc_pkg::t_frame_out o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data
);
    import skc_pkg::*;

    t_cfg     r_cfg;
    logic     r_enable;
    logic     w_wr;
    logic     w_env_load;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;
    assign w_env_load  = w_wr && (i_cfg_index == CFG_ENABLE) && i_cfg_data[0] && !r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_db  <= RST_THRESHOLD;
            r_cfg.inverse_ratio <= RST_INV_RATIO;
            r_cfg.knee_width_db <= RST_KNEE;
            r_cfg.attack_coeff  <= RST_ATTACK;
            r_cfg.release_coeff <= RST_RELEASE;
            r_cfg.makeup_gain   <= RST_MAKEUP;
            r_enable            <= 1'b0;
        end else if (w_wr) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.threshold_db  <= $signed(i_cfg_data[14:0]);
                CFG_INV_RATIO: r_cfg.inverse_ratio <= i_cfg_data;
                CFG_KNEE:      r_cfg.knee_width_db <= i_cfg_data[12:0];
                CFG_ATTACK:    r_cfg.attack_coeff  <= i_cfg_data[15:0];
                CFG_RELEASE:   r_cfg.release_coeff <= i_cfg_data[15:0];
                CFG_MAKEUP:    r_cfg.makeup_gain   <= i_cfg_data;
                CFG_ENABLE:    r_enable            <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    skc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_enable    (r_enable),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    skc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_word     (i_in_word),
        .i_cfg      (r_cfg),
        .i_env_load (w_env_load),
        .o_word     (o_out_word)
    );

endmodule

@@ design/skc_chk.sv @@
// ----------------------------------------------------------------------------
// skc_chk
// Port-level checks of the compressor, bound to the top level.
// ----------------------------------------------------------------------------
module skc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input skc_pkg::t_frame_out o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("output word changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        (!$past(i_rst_n) && i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after taking a word");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output word appeared with no word in flight");

endmodule

bind stereo_soft_knee_compressor skc_chk u_chk (.*);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo soft-knee compressor. Frames go in with
// random gaps, results are taken under random stalls and long hold-offs, and
// each output word is checked against an in-bench fixed-point predictor of
// the level detector, envelope, gain computer, exp2 and scaler. Registers are
// changed only while the block is idle, covering reset, extreme and random
// settings, bypass and enable reload.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skc_pkg::*;

    localparam int HOLD_LEN  = 300;
    localparam int WDOG_MAX  = 4000;
    localparam int DRAIN_GAP = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_frame_in   i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_frame_out  o_out_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_THRESHOLD;
    logic [16:0] i_cfg_data = '0;

    stereo_soft_knee_compressor u_top (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [14:0] thr_db;
    logic [16:0]        inv_ratio;
    logic [12:0]        knee_db;
    logic [15:0]        atk_coeff;
    logic [15:0]        rel_coeff;
    logic [16:0]        makeup;
    logic               comp_on;
    logic signed [16:0] env_db;

    t_frame_out frame_q[$];
    int  n_errors = 0;
    bit  gaps_on = 1'b1;
    int  sink_hold = 0;
    int  hold_req = 0;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
        n_errors++;
    endtask

    function automatic longint peak_to_db(longint unsigned p);
        int e;
        longint unsigned f, frac, neg, mag;
        if (p == 0) return -24576;
        e = 0;
        while (e < 63 && (p >> (e + 1)) != 0) e++;
        f = ((p << (31 - e)) >> 8) & 64'h7FFFFF;
        frac = f - ((f * ((64'd1 << 23) + f) * 64'd22589) >> 39);
        neg = (longint'(23 - e) << 23) - frac;
        mag = (neg * 64'd394566 + (64'd1 << 30)) >> 31;
        return -longint'(mag);
    endfunction

    function automatic longint gain_from_env(longint env);
        longint d, w, s;
        longint unsigned y2, num, den, q;
        d = env - longint'(thr_db);
        w = longint'(knee_db);
        s = longint'(inv_ratio) - 65536;
        if (2 * d <= -w) return 0;
        if (2 * d >= w) return (d * s + 32768) >>> 16;
        y2 = 2 * d + w;
        num = longint'(s < 0 ? -s : s) * y2 * y2;
        den = 8 * w * 65536;
        q = (num + den / 2) / den;
        return s < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [23:0] scale_one(longint smp, longint unsigned gm, longint xi);
        longint unsigned mag, mo;
        longint sh, v;
        bit sat;
        mag = longint'(smp < 0 ? -smp : smp) * gm;
        sh = 23 - xi;
        sat = 1'b0;
        if (sh > 0) mo = (sh > 62) ? 0 : ((mag + (64'd1 << (sh - 1))) >> sh);
        else if (mag == 0) mo = 0;
        else if (-sh > 40 || (mag >> (63 + sh)) != 0) begin
            mo = 0;
            sat = 1'b1;
        end else mo = mag << (-sh);
        if (sat || mo > (64'd1 << 24)) v = smp < 0 ? -8388608 : 8388607;
        else v = smp < 0 ? -longint'(mo) : longint'(mo);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic t_frame_out compress_frame(t_frame_in w);
        t_frame_out o;
        longint l, r, lvl, env, g, x, xi;
        longint unsigned al, ar, coeff, xf, poly, gm;
        if (!comp_on) begin
            o.left_out = w.left_in;
            o.right_out = w.right_in;
            return o;
        end
        l = longint'(w.left_in);
        r = longint'(w.right_in);
        al = l < 0 ? -l : l;
        ar = r < 0 ? -r : r;
        lvl = peak_to_db(al > ar ? al : ar);
        coeff = (lvl > longint'(env_db)) ? atk_coeff : rel_coeff;
        env = lvl + ((longint'(coeff) * (longint'(env_db) - lvl) + 32768) >>> 16);
        if (env > 65535) env = 65535;
        if (env < -65536) env = -65536;
        env_db = env[16:0];
        g = gain_from_env(env);
        x = (g * 2786635 + 256) >>> 9;
        xi = x >>> 23;
        xf = x & 64'h7FFFFF;
        poly = (64'd1 << 23) + ((xf * ((64'd42947 << 23) + 64'd22589 * xf)) >> 39);
        gm = (poly * makeup) >> 12;
        o.left_out = scale_one(l, gm, xi);
        o.right_out = scale_one(r, gm, xi);
        return o;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [16:0] val);
        case (idx)
            CFG_THRESHOLD: thr_db = val[14:0];
            CFG_INV_RATIO: inv_ratio = val;
            CFG_KNEE:      knee_db = val[12:0];
            CFG_ATTACK:    atk_coeff = val[15:0];
            CFG_RELEASE:   rel_coeff = val[15:0];
            CFG_MAKEUP:    makeup = val;
            CFG_ENABLE: begin
                if (val[0] && !comp_on) env_db = 17'(thr_db);
                comp_on = val[0];
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [23:0] pick_sample();
        int r;
        logic [23:0] v;
        r = $urandom_range(0, 19);
        if (r == 0) return 24'h000000;
        if (r == 1) return 24'h7FFFFF;
        if (r == 2) return 24'h800000;
        v = 24'($urandom) >> $urandom_range(0, 23);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        int r;
        if (hold_req > 0) begin
            i_out_ready <= 1'b0;
            sink_hold <= hold_req;
            hold_req = 0;
        end else if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (!gaps_on) begin
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) i_out_ready <= 1'b1;
            else if (r < 97) i_out_ready <= 1'b0;
            else begin
                i_out_ready <= 1'b0;
                sink_hold <= $urandom_range(10, 40);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_q.size() == 0) begin
                $display("unexpected word: %0d %0d", o_out_word.left_out,
                         o_out_word.right_out);
                n_errors++;
            end else begin
                want = frame_q.pop_front();
                if (o_out_word.left_out !== want.left_out)
                    report_mismatch("left", o_out_word.left_out, want.left_out);
                if (o_out_word.right_out !== want.right_out)
                    report_mismatch("right", o_out_word.right_out, want.right_out);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        int idle_cnt;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WDOG_MAX) begin
            $display("** stereo_soft_knee_compressor: FAILED **");
            $finish;
        end
    end

    task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
        int gap;
        t_frame_in w;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.left_in = l;
        w.right_in = r;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        frame_q.push_back(compress_frame(w));
    endtask

    task automatic wait_drain();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input int thr, input int inv, input int knee,
                           input int atk, input int rel, input int mk);
        wait_drain();
        write_reg(CFG_THRESHOLD, 17'(thr));
        write_reg(CFG_INV_RATIO, 17'(inv));
        write_reg(CFG_KNEE, 17'(knee));
        write_reg(CFG_ATTACK, 17'(atk));
        write_reg(CFG_RELEASE, 17'(rel));
        write_reg(CFG_MAKEUP, 17'(mk));
    endtask

    task automatic test_bypass();
        send_frame(24'h000000, 24'h7FFFFF);
        send_frame(24'h800000, 24'hFFFFFF);
        send_frame(24'h000001, 24'h555555);
        send_frame(24'hAAAAAA, 24'h800000);
    endtask

    task automatic test_directed();
        wait_drain();
        write_reg(CFG_ENABLE, 17'd1);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h000001, 24'hFFFFFF);
        // zero coefficients, expander ratio, hard knee
        set_all(-15360, 131071, 0, 0, 0, 4096);
        send_frame(24'h7FFFFF, 24'h000010);
        send_frame(24'h000100, 24'h000000);
        // strongest compression, a wide knee, high makeup
        set_all(0, 3277, 5120, 65535, 65535, 129523);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        send_frame(24'h012345, 24'hFEDCBA);
        // huge gain saturates
        set_all(-15360, 131071, 8191, 0, 0, 131071);
        send_frame(24'h000001, 24'hFFFFFF);
        send_frame(24'h400000, 24'h000000);
        // re-enable while on keeps the envelope, off then on reloads it
        wait_drain();
        write_reg(CFG_ENABLE, 17'd1);
        send_frame(24'h001000, 24'h002000);
        wait_drain();
        write_reg(CFG_ENABLE, 17'd0);
        send_frame(24'h123456, 24'h800000);
        wait_drain();
        write_reg(CFG_THRESHOLD, 17'h7FFF & 17'(-2560));
        write_reg(CFG_ENABLE, 17'd1);
        send_frame(24'h100000, 24'h000000);
    endtask

    task automatic test_backpressure();
        int k;
        set_all(-5120, 16384, 1536, 60000, 65000, 8192);
        hold_req = HOLD_LEN;
        for (k = 0; k < 20; k++) send_frame(pick_sample(), pick_sample());
        // sender waits until everything is out
        wait_drain();
        for (k = 0; k < 20; k++) send_frame(pick_sample(), pick_sample());
    endtask

    task automatic test_random();
        int ph, k, thr, inv, mk;
        for (ph = 0; ph < 12; ph++) begin
            gaps_on = (ph % 4) != 3;
            thr = -$urandom_range(0, 15360);
            inv = ($urandom_range(0, 7) == 0) ? $urandom_range(65537, 131071)
                                               : $urandom_range(3277, 65536);
            mk = ($urandom_range(0, 7) == 0) ? $urandom_range(129524, 131071)
                                              : $urandom_range(4096, 129523);
            set_all(thr, inv, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5120),
                    $urandom_range(0, 65535), $urandom_range(0, 65535), mk);
            if (ph % 5 == 4) begin
                write_reg(CFG_ENABLE, 17'd0);
                write_reg(CFG_ENABLE, 17'd1);
            end
            if (ph == 6) write_reg(CFG_ENABLE, 17'd0);
            if (ph == 7) write_reg(CFG_ENABLE, 17'd1);
            for (k = 0; k < 150; k++) begin
                // loud bursts and quiet stretches drive attack and release
                if ((k / 25) % 2 == 0) send_frame(pick_sample(), pick_sample());
                else send_frame(24'(pick_sample()) >>> 12, 24'(pick_sample()) >>> 12);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        apply_reg(CFG_THRESHOLD, 17'h7FFF & 17'(RST_THRESHOLD));
        inv_ratio = RST_INV_RATIO;
        knee_db = RST_KNEE;
        atk_coeff = RST_ATTACK;
        rel_coeff = RST_RELEASE;
        makeup = RST_MAKEUP;
        comp_on = 1'b0;
        env_db = LVL_FLOOR;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_bypass();
        test_directed();
        test_backpressure();
        test_random();
        wait_drain();
        if (n_errors == 0 && frame_q.size() == 0) begin
            $display("** stereo_soft_knee_compressor: PASSED **");
        end else begin
            $display("** stereo_soft_knee_compressor: FAILED **");
        end
        $finish;
    end
endmodule
